FILE: src/lcdseq_pkg.sv
`default_nettype none

package lcdseq_pkg;

  localparam int unsigned WAIT_W = 16;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned NIB_W  = 4;
  localparam int unsigned IDX_W  = 4;

  typedef enum logic [1:0] {
    OP_DATA   = 2'd0,
    OP_CMD    = 2'd1,
    OP_CURSOR = 2'd2,
    OP_INIT   = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    CFG_SHORT_WAIT   = 3'd0,
    CFG_LONG_WAIT    = 3'd1,
    CFG_POWER_WAIT   = 3'd2,
    CFG_INIT1_WAIT   = 3'd3,
    CFG_INIT2_WAIT   = 3'd4,
    CFG_FUNC_SET     = 3'd5,
    CFG_DISPLAY      = 3'd6,
    CFG_ENTRY        = 3'd7
  } cfg_reg_e;

  localparam logic [WAIT_W-1:0] RST_SHORT_WAIT = 16'd40;
  localparam logic [WAIT_W-1:0] RST_LONG_WAIT  = 16'd1640;
  localparam logic [WAIT_W-1:0] RST_POWER_WAIT = 16'd15000;
  localparam logic [WAIT_W-1:0] RST_INIT1_WAIT = 16'd5000;
  localparam logic [WAIT_W-1:0] RST_INIT2_WAIT = 16'd100;
  localparam logic [BYTE_W-1:0] RST_FUNC_SET   = 8'd40;
  localparam logic [BYTE_W-1:0] RST_DISPLAY    = 8'd12;
  localparam logic [BYTE_W-1:0] RST_ENTRY      = 8'd6;

  localparam logic [BYTE_W-1:0] CLEAR_CMD       = 8'h01;
  localparam logic [BYTE_W-1:0] HOME_CMD        = 8'h02;
  localparam logic [NIB_W-1:0]  INIT_NIBBLE     = 4'h3;
  localparam logic [NIB_W-1:0]  FOUR_BIT_NIBBLE = 4'h2;

  localparam logic [IDX_W-1:0] BYTE_LAST_IDX = 4'd1;
  localparam logic [IDX_W-1:0] INIT_LAST_IDX = 4'd13;

  typedef struct packed {
    logic [1:0]        operation;
    logic [BYTE_W-1:0] byte_value;
    logic [BYTE_W-1:0] column;
    logic [1:0]        row;
  } lcd_req_t;

  typedef struct packed {
    logic              select_level;
    logic [NIB_W-1:0]  nibble;
    logic [WAIT_W-1:0] wait_before;
    logic [WAIT_W-1:0] wait_after;
    logic              last;
  } lcd_strobe_t;

  typedef struct packed {
    logic [WAIT_W-1:0] short_wait;
    logic [WAIT_W-1:0] long_wait;
    logic [WAIT_W-1:0] power_on_wait;
    logic [WAIT_W-1:0] init_first_wait;
    logic [WAIT_W-1:0] init_second_wait;
    logic [BYTE_W-1:0] function_set_byte;
    logic [BYTE_W-1:0] display_byte;
    logic [BYTE_W-1:0] entry_byte;
  } lcd_cfg_t;

  function automatic logic [BYTE_W-1:0] row_base(input logic [1:0] row);
    logic [BYTE_W-1:0] base;
    unique case (row)
      2'd0:    base = 8'h80;
      2'd1:    base = 8'hC0;
      2'd2:    base = 8'h94;
      default: base = 8'hD4;
    endcase
    return base;
  endfunction

endpackage

`default_nettype wire

FILE: src/lcdseq_cfg_regs.sv
`default_nettype none

module lcdseq_cfg_regs (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire lcdseq_pkg::cfg_reg_e           cfg_index,
  input  wire logic [lcdseq_pkg::WAIT_W-1:0]  cfg_wdata,
  output lcdseq_pkg::lcd_cfg_t                cfg
);
  import lcdseq_pkg::*;

  lcd_cfg_t cfg_r;
  lcd_cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_SHORT_WAIT: cfg_nxt.short_wait        = cfg_wdata;
        CFG_LONG_WAIT:  cfg_nxt.long_wait         = cfg_wdata;
        CFG_POWER_WAIT: cfg_nxt.power_on_wait     = cfg_wdata;
        CFG_INIT1_WAIT: cfg_nxt.init_first_wait   = cfg_wdata;
        CFG_INIT2_WAIT: cfg_nxt.init_second_wait  = cfg_wdata;
        CFG_FUNC_SET:   cfg_nxt.function_set_byte = cfg_wdata[BYTE_W-1:0];
        CFG_DISPLAY:    cfg_nxt.display_byte      = cfg_wdata[BYTE_W-1:0];
        CFG_ENTRY:      cfg_nxt.entry_byte        = cfg_wdata[BYTE_W-1:0];
        default:        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.short_wait        <= RST_SHORT_WAIT;
      cfg_r.long_wait         <= RST_LONG_WAIT;
      cfg_r.power_on_wait     <= RST_POWER_WAIT;
      cfg_r.init_first_wait   <= RST_INIT1_WAIT;
      cfg_r.init_second_wait  <= RST_INIT2_WAIT;
      cfg_r.function_set_byte <= RST_FUNC_SET;
      cfg_r.display_byte      <= RST_DISPLAY;
      cfg_r.entry_byte        <= RST_ENTRY;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

FILE: src/lcdseq_strobe_gen.sv
`default_nettype none

module lcdseq_strobe_gen (
  input  lcdseq_pkg::lcd_req_t                req,
  input  wire logic [lcdseq_pkg::IDX_W-1:0]   idx,
  input  lcdseq_pkg::lcd_cfg_t                cfg,
  output lcdseq_pkg::lcd_strobe_t             strobe
);
  import lcdseq_pkg::*;

  logic [BYTE_W-1:0] byte_sel;
  logic [BYTE_W-1:0] cursor_addr;
  logic [BYTE_W-1:0] init_cmd;
  logic [WAIT_W-1:0] cmd_wait;
  logic              high_half;

  assign cursor_addr = row_base(req.row) + req.column;
  assign high_half   = ~idx[0];

  // two strobes per command byte of the init sequence, from strobe four on
  always_comb begin
    unique case (idx[3:1])
      3'd2:    init_cmd = cfg.function_set_byte;
      3'd3:    init_cmd = cfg.display_byte;
      3'd4:    init_cmd = cfg.entry_byte;
      3'd5:    init_cmd = CLEAR_CMD;
      default: init_cmd = HOME_CMD;
    endcase
  end

  always_comb begin
    unique case (op_e'(req.operation))
      OP_DATA:   byte_sel = req.byte_value;
      OP_CMD:    byte_sel = req.byte_value;
      OP_CURSOR: byte_sel = cursor_addr;
      default:   byte_sel = init_cmd;
    endcase
  end

  // clear and home need the long wait; cursor moves never do
  assign cmd_wait = (byte_sel <= HOME_CMD) ? cfg.long_wait : cfg.short_wait;

  always_comb begin
    strobe.select_level = 1'b0;
    strobe.nibble       = high_half ? byte_sel[7:4] : byte_sel[3:0];
    strobe.wait_before  = '0;
    strobe.wait_after   = high_half ? '0 : cfg.short_wait;
    strobe.last         = (idx == BYTE_LAST_IDX);
    unique case (op_e'(req.operation))
      OP_DATA: begin
        strobe.select_level = 1'b1;
      end
      OP_CMD: begin
        strobe.wait_after = high_half ? '0 : cmd_wait;
      end
      OP_CURSOR: begin
      end
      default: begin
        strobe.last = (idx == INIT_LAST_IDX);
        priority case (idx)
          4'd0: begin
            strobe.nibble      = INIT_NIBBLE;
            strobe.wait_before = cfg.power_on_wait;
            strobe.wait_after  = cfg.init_first_wait;
          end
          4'd1: begin
            strobe.nibble     = INIT_NIBBLE;
            strobe.wait_after = cfg.init_second_wait;
          end
          4'd2: begin
            strobe.nibble     = INIT_NIBBLE;
            strobe.wait_after = cfg.short_wait;
          end
          4'd3: begin
            strobe.nibble     = FOUR_BIT_NIBBLE;
            strobe.wait_after = cfg.short_wait;
          end
          default: begin
            strobe.wait_after = high_half ? '0 : cmd_wait;
          end
        endcase
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: src/char_lcd_nibble_write_sequencer.sv
`default_nettype none
// The request is registered, and each strobe formed from it is registered again
// before it appears on out_data. Throughput: one strobe per cycle; byte requests give 2
// strobes, init 14, set by the strobe index counter that walks the request register.
// The next request is taken in the cycle that forms the current last strobe.
// Synchronous active-low reset drops the active request and the output
// strobe and loads the configuration registers with their defaults.

module char_lcd_nibble_write_sequencer (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           start,
  output logic                                busy,
  input  lcdseq_pkg::lcd_req_t                in_req,
  output logic                                out_valid,
  output lcdseq_pkg::lcd_strobe_t             out_data,
  input  wire logic                           cfg_we,
  input  wire lcdseq_pkg::cfg_reg_e           cfg_index,
  input  wire logic [lcdseq_pkg::WAIT_W-1:0]  cfg_wdata
);
  import lcdseq_pkg::*;

  lcd_cfg_t          cfg;
  lcd_req_t          req_r;
  logic [IDX_W-1:0]  idx_r;
  logic [IDX_W-1:0]  idx_nxt;
  logic              active_r;
  logic              active_nxt;
  lcd_strobe_t       strobe;
  lcd_strobe_t       out_data_r;
  logic              out_valid_r;
  logic              accept;

  lcdseq_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  lcdseq_strobe_gen u_gen (
    .req    (req_r),
    .idx    (idx_r),
    .cfg    (cfg),
    .strobe (strobe)
  );

  assign busy   = active_r & ~strobe.last;
  assign accept = start & ~busy;

  always_comb begin
    idx_nxt    = idx_r + 1'b1;
    active_nxt = active_r;
    if (accept) begin
      idx_nxt    = '0;
      active_nxt = 1'b1;
    end else if (active_r && strobe.last) begin
      active_nxt = 1'b0;
    end else if (!active_r) begin
      idx_nxt = idx_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      active_r    <= active_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= active_r;
    end
  end

  // payload: hold request while walking it, capture each strobe
  always_ff @(posedge clk) begin
    if (accept) begin
      req_r <= in_req;
    end
    out_data_r <= strobe;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

FILE: src/lcdseq_checker.sv
`default_nettype none

module lcdseq_checker (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           start,
  input  wire logic                           busy,
  input  wire logic                           out_valid,
  input  lcdseq_pkg::lcd_strobe_t             out_data
);
  import lcdseq_pkg::*;

  // no strobe straight out of reset
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("strobe right after reset");

  // strobes of one request come in consecutive cycles
  a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.last |=> out_valid)
    else $error("gap inside a request");

  // a taken request shows its first strobe once it has passed the request and output registers
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |-> ##2 out_valid)
    else $error("request produced no strobe");

  // register select holds for the whole request
  a_sel_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.last |=> out_data.select_level == $past(out_data.select_level))
    else $error("register select changed inside a request");

endmodule

bind char_lcd_nibble_write_sequencer lcdseq_checker u_lcdseq_checker (.*);

`default_nettype wire

FILE: tb/lcd_strobe_checker.sv
`default_nettype none

module lcd_strobe_checker
  import lcdseq_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic               busy,
  input  lcd_req_t                in_req,
  input  wire logic               out_valid,
  input  lcd_strobe_t             out_data,
  input  wire logic               cfg_we,
  input  cfg_reg_e                cfg_index,
  input  wire logic [WAIT_W-1:0]  cfg_wdata,
  output int unsigned             fail_count,
  output int unsigned             pending
);

  localparam logic [BYTE_W-1:0] ROW_ADDR [4] = '{8'h80, 8'hC0, 8'h94, 8'hD4};

  lcd_cfg_t    regs;
  lcd_strobe_t strobes_due[$];
  lcd_strobe_t planned[$];

  task automatic plan_strobe(input logic sel, input logic [NIB_W-1:0] nib,
                             input logic [WAIT_W-1:0] pre_wait,
                             input logic [WAIT_W-1:0] after);
    lcd_strobe_t s;
    s.select_level = sel;
    s.nibble       = nib;
    s.wait_before  = pre_wait;
    s.wait_after   = after;
    s.last         = 1'b0;
    planned.push_back(s);
  endtask

  // High nibble first, wait only after the low one.
  task automatic plan_byte(input logic sel, input logic [BYTE_W-1:0] b,
                           input logic [WAIT_W-1:0] after);
    plan_strobe(sel, b[7:4], '0, '0);
    plan_strobe(sel, b[3:0], '0, after);
  endtask

  // Clear and home need the long wait.
  task automatic plan_command(input logic [BYTE_W-1:0] b);
    plan_byte(1'b0, b, (b <= HOME_CMD) ? regs.long_wait : regs.short_wait);
  endtask

  task automatic plan_request(input lcd_req_t req);
    logic [BYTE_W-1:0] addr;
    planned.delete();
    case (op_e'(req.operation))
      OP_DATA: begin
        plan_byte(1'b1, req.byte_value, regs.short_wait);
      end
      OP_CMD: begin
        plan_command(req.byte_value);
      end
      OP_CURSOR: begin
        // wrap at 8 bits, no long wait for low addresses
        addr = ROW_ADDR[req.row] + req.column;
        plan_byte(1'b0, addr, regs.short_wait);
      end
      default: begin
        plan_strobe(1'b0, INIT_NIBBLE, regs.power_on_wait, regs.init_first_wait);
        plan_strobe(1'b0, INIT_NIBBLE, '0, regs.init_second_wait);
        plan_strobe(1'b0, INIT_NIBBLE, '0, regs.short_wait);
        plan_strobe(1'b0, FOUR_BIT_NIBBLE, '0, regs.short_wait);
        plan_command(regs.function_set_byte);
        plan_command(regs.display_byte);
        plan_command(regs.entry_byte);
        plan_command(CLEAR_CMD);
        plan_command(HOME_CMD);
      end
    endcase
    planned[planned.size()-1].last = 1'b1;
    foreach (planned[i]) strobes_due.push_back(planned[i]);
  endtask

  task automatic compare_field(input string name, input logic [WAIT_W-1:0] want,
                               input logic [WAIT_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      fail_count++;
    end
  endtask

  task automatic check_strobe(input lcd_strobe_t got);
    lcd_strobe_t want;
    if (strobes_due.size() == 0) begin
      $error("strobe with no request pending: %h", got);
      fail_count++;
    end else begin
      want = strobes_due.pop_front();
      compare_field("select_level", WAIT_W'(want.select_level), WAIT_W'(got.select_level));
      compare_field("nibble", WAIT_W'(want.nibble), WAIT_W'(got.nibble));
      compare_field("wait_before", want.wait_before, got.wait_before);
      compare_field("wait_after", want.wait_after, got.wait_after);
      compare_field("last", WAIT_W'(want.last), WAIT_W'(got.last));
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      regs = '{short_wait: RST_SHORT_WAIT, long_wait: RST_LONG_WAIT,
               power_on_wait: RST_POWER_WAIT, init_first_wait: RST_INIT1_WAIT,
               init_second_wait: RST_INIT2_WAIT, function_set_byte: RST_FUNC_SET,
               display_byte: RST_DISPLAY, entry_byte: RST_ENTRY};
      strobes_due.delete();
    end else begin
      // retire first so a request taken on this edge never meets its own strobe
      if (out_valid) check_strobe(out_data);
      if (start && !busy) plan_request(in_req);
      if (cfg_we) begin
        case (cfg_index)
          CFG_SHORT_WAIT: regs.short_wait        = cfg_wdata;
          CFG_LONG_WAIT:  regs.long_wait         = cfg_wdata;
          CFG_POWER_WAIT: regs.power_on_wait     = cfg_wdata;
          CFG_INIT1_WAIT: regs.init_first_wait   = cfg_wdata;
          CFG_INIT2_WAIT: regs.init_second_wait  = cfg_wdata;
          CFG_FUNC_SET:   regs.function_set_byte = cfg_wdata[BYTE_W-1:0];
          CFG_DISPLAY:    regs.display_byte      = cfg_wdata[BYTE_W-1:0];
          default:        regs.entry_byte        = cfg_wdata[BYTE_W-1:0];
        endcase
      end
    end
    pending = strobes_due.size();
  end

endmodule

`default_nettype wire

FILE: tb/char_lcd_nibble_write_sequencer_tb.sv
`default_nettype none

module char_lcd_nibble_write_sequencer_tb;
  import lcdseq_pkg::*;

  localparam int unsigned STALL_LIMIT = 1000;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  lcd_req_t          in_req = '0;
  logic              out_valid;
  lcd_strobe_t       out_data;
  logic              cfg_we = 1'b0;
  cfg_reg_e          cfg_index = CFG_SHORT_WAIT;
  logic [WAIT_W-1:0] cfg_wdata = '0;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned quiet_cycles = 0;
  int unsigned calm_items = 0;

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  char_lcd_nibble_write_sequencer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  lcd_strobe_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_req     (in_req),
    .out_valid  (out_valid),
    .out_data   (out_data),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // Abort if nothing moves on any port for too long.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Hold the request until the block takes it; keep start high on back-to-back.
  task automatic send(input op_e op, input logic [BYTE_W-1:0] value,
                      input logic [BYTE_W-1:0] col, input logic [1:0] row);
    int unsigned gap;
    logic        taken;
    if (calm_items != 0) begin
      gap = 0;
      calm_items--;
    end else begin
      gap = $urandom_range(0, 14);
      if ($urandom_range(0, 7) == 0) calm_items = $urandom_range(3, 10);
    end
    if (gap != 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_req.operation  = op;
    in_req.byte_value = value;
    in_req.column     = col;
    in_req.row        = row;
    start = 1'b1;
    do begin
      @(posedge clk);
      taken = !busy;
      @(negedge clk);
    end while (!taken);
  endtask

  task automatic send_random();
    op_e               op;
    logic [BYTE_W-1:0] value;
    op    = op_e'($urandom_range(0, 3));
    value = BYTE_W'($urandom);
    if (op == OP_CMD && $urandom_range(0, 3) == 0) value = BYTE_W'($urandom_range(0, 3));
    send(op, value, BYTE_W'($urandom), 2'($urandom));
  endtask

  // Drop start and wait for the last strobe before touching registers.
  task automatic drain();
    start = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [WAIT_W-1:0] value);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  // Byte registers get junk in the upper half, which must be dropped.
  task automatic load_config(input logic [WAIT_W-1:0] sw, input logic [WAIT_W-1:0] lw,
                             input logic [WAIT_W-1:0] pw, input logic [WAIT_W-1:0] w1,
                             input logic [WAIT_W-1:0] w2, input logic [BYTE_W-1:0] fs,
                             input logic [BYTE_W-1:0] dc, input logic [BYTE_W-1:0] em);
    write_reg(CFG_SHORT_WAIT, sw);
    write_reg(CFG_LONG_WAIT, lw);
    write_reg(CFG_POWER_WAIT, pw);
    write_reg(CFG_INIT1_WAIT, w1);
    write_reg(CFG_INIT2_WAIT, w2);
    write_reg(CFG_FUNC_SET, {8'($urandom), fs});
    write_reg(CFG_DISPLAY, {8'($urandom), dc});
    write_reg(CFG_ENTRY, {8'($urandom), em});
  endtask

  function automatic logic [WAIT_W-1:0] pick_wait();
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return '1;
      2:       return WAIT_W'($urandom_range(0, 63));
      default: return WAIT_W'($urandom);
    endcase
  endfunction

  // Favour clear/home values so init also meets the long wait.
  function automatic logic [BYTE_W-1:0] pick_byte();
    case ($urandom_range(0, 3))
      0:       return BYTE_W'($urandom_range(0, 2));
      1:       return '1;
      default: return BYTE_W'($urandom);
    endcase
  endfunction

  initial begin
    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    // defaults after reset
    send(OP_DATA, 8'h00, 8'h00, 2'd0);
    send(OP_DATA, 8'hFF, 8'hFF, 2'd3);
    send(OP_DATA, 8'hA5, 8'h5A, 2'd1);
    send(OP_CMD, 8'h00, 8'hFF, 2'd3);
    send(OP_CMD, CLEAR_CMD, 8'h00, 2'd0);
    send(OP_CMD, HOME_CMD, 8'h00, 2'd0);
    send(OP_CMD, 8'h03, 8'h00, 2'd0);
    send(OP_CMD, 8'hFF, 8'h00, 2'd2);
    send(OP_CURSOR, 8'hFF, 8'h00, 2'd0);
    send(OP_CURSOR, 8'h00, 8'h00, 2'd1);
    send(OP_CURSOR, 8'h00, 8'h00, 2'd2);
    send(OP_CURSOR, 8'h00, 8'h00, 2'd3);
    send(OP_CURSOR, 8'h00, 8'hFF, 2'd3);
    send(OP_CURSOR, 8'h00, 8'h7F, 2'd0);
    send(OP_CURSOR, 8'h00, 8'h80, 2'd0);
    send(OP_CURSOR, 8'h00, 8'h3F, 2'd1);
    send(OP_INIT, 8'h00, 8'h00, 2'd0);
    send(OP_INIT, 8'hFF, 8'hFF, 2'd3);

    drain();
    load_config('1, '1, '1, '1, '1, '1, '1, '1);
    send(OP_INIT, 8'h00, 8'h00, 2'd0);
    repeat (12) send_random();

    drain();
    load_config('0, '0, '0, '0, '0, '0, '0, '0);
    send(OP_INIT, 8'h00, 8'h00, 2'd0);
    repeat (12) send_random();

    repeat (4) begin
      drain();
      load_config(pick_wait(), pick_wait(), pick_wait(), pick_wait(), pick_wait(),
                  pick_byte(), pick_byte(), pick_byte());
      send(OP_INIT, BYTE_W'($urandom), BYTE_W'($urandom), 2'($urandom));
      repeat (18) send_random();
    end

    start = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire
